@@ rtl/atr_pkg.sv @@
// Shared constants, types and character helpers for the AT response hex payload decoder.
`default_nettype none

package atr_pkg;

    // Largest payload length the decoder accepts; longer declared lengths saturate.
    localparam int unsigned MaxContentBytes = 255;
    localparam int unsigned LenW            = $clog2(MaxContentBytes + 1);

    // Character and field widths.
    localparam int unsigned CharW   = 8;
    localparam int unsigned NibbleW = 4;
    localparam int unsigned CommaW  = 3;

    // Parse phases.
    localparam logic [1:0] PhHeader  = 2'd0;
    localparam logic [1:0] PhPayload = 2'd1;
    localparam logic [1:0] PhDone    = 2'd2;

    // Header layout: the length is the fourth comma-separated field.
    localparam logic [CharW-1:0]  FieldSep     = 8'h2C;
    localparam logic [CommaW-1:0] LengthField  = 3'd3;
    localparam logic [CommaW-1:0] HeaderFields = 3'd4;

    // One decoded result item.
    typedef struct packed {
        logic             capped;
        logic             last;
        logic             has_data;
        logic [CharW-1:0] data;
    } t_result;

    // True for an ASCII decimal digit.
    function automatic logic is_digit(input logic [CharW-1:0] c);
        return (c inside {[8'h30 : 8'h39]});
    endfunction

    // Hex value of an ASCII character; anything that is not a hex digit reads as zero.
    function automatic logic [NibbleW-1:0] nibble_of(input logic [CharW-1:0] c);
        logic [NibbleW-1:0] v;
        v = '0;
        if (c inside {[8'h30 : 8'h39]}) begin
            v = c[NibbleW-1:0];
        end else if (c inside {[8'h41 : 8'h46], [8'h61 : 8'h66]}) begin
            v = c[NibbleW-1:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/atr_parse.sv @@
// Parse state and per-character update: header commas, length digits and hex byte assembly.
`default_nettype none

module atr_parse
    import atr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [CharW-1:0] i_char,
    input  wire logic             i_start,
    output logic                  o_res_valid,
    output t_result               o_res
);

    logic [1:0]         r_phase,   n_phase;
    logic [CommaW-1:0]  r_commas,  n_commas;
    logic [LenW-1:0]    r_len,     n_len;
    logic               r_ended,   n_ended;
    logic               r_capped,  n_capped;
    logic [LenW-1:0]    r_remain,  n_remain;
    logic [NibbleW-1:0] r_hi,      n_hi;
    logic               r_pending, n_pending;

    // State as seen by this character: a start flag clears it first.
    logic [1:0]         c_phase;
    logic [CommaW-1:0]  c_commas;
    logic [LenW-1:0]    c_len;
    logic               c_ended;
    logic               c_capped;
    logic [LenW-1:0]    c_remain;
    logic [NibbleW-1:0] c_hi;
    logic               c_pending;

    logic [CommaW-1:0]  commas_inc;
    logic [LenW+3:0]    len_next;
    logic [LenW-1:0]    remain_dec;

    assign c_phase   = i_start ? PhHeader : r_phase;
    assign c_commas  = i_start ? '0 : r_commas;
    assign c_len     = i_start ? '0 : r_len;
    assign c_ended   = i_start ? 1'b0 : r_ended;
    assign c_capped  = i_start ? 1'b0 : r_capped;
    assign c_remain  = i_start ? '0 : r_remain;
    assign c_hi      = i_start ? '0 : r_hi;
    assign c_pending = i_start ? 1'b0 : r_pending;

    assign commas_inc = c_commas + 1'b1;
    assign len_next   = {4'd0, c_len} * (LenW+4)'(10)
                        + (LenW+4)'(i_char - 8'h30);
    assign remain_dec = (c_remain != '0) ? c_remain - 1'b1 : c_remain;

    // Next-state logic for one character.
    always_comb begin
        n_phase     = c_phase;
        n_commas    = c_commas;
        n_len       = c_len;
        n_ended     = c_ended;
        n_capped    = c_capped;
        n_remain    = c_remain;
        n_hi        = c_hi;
        n_pending   = c_pending;
        o_res_valid = 1'b0;
        o_res       = '{capped: c_capped, last: 1'b0, has_data: 1'b0, data: '0};
        case (c_phase)
            PhHeader: begin
                if (i_char == FieldSep) begin
                    n_commas = commas_inc;
                    if (commas_inc >= HeaderFields) begin
                        if (c_len == '0) begin
                            n_phase     = PhDone;
                            o_res_valid = 1'b1;
                            o_res.last  = 1'b1;
                        end else begin
                            n_remain  = c_len;
                            n_pending = 1'b0;
                            n_phase   = PhPayload;
                        end
                    end
                end else if (c_commas == LengthField && !c_ended) begin
                    if (is_digit(i_char)) begin
                        if (len_next > (LenW+4)'(MaxContentBytes)) begin
                            n_len    = LenW'(MaxContentBytes);
                            n_capped = 1'b1;
                        end else begin
                            n_len = len_next[LenW-1:0];
                        end
                    end else begin
                        n_ended = 1'b1;
                    end
                end
            end
            PhPayload: begin
                if (!c_pending) begin
                    n_hi      = nibble_of(i_char);
                    n_pending = 1'b1;
                end else begin
                    n_pending      = 1'b0;
                    n_hi           = '0;
                    n_remain       = remain_dec;
                    o_res_valid    = 1'b1;
                    o_res.has_data = 1'b1;
                    o_res.data     = {c_hi, nibble_of(i_char)};
                    o_res.last     = (remain_dec == '0);
                    if (remain_dec == '0) begin
                        n_phase = PhDone;
                    end
                end
            end
            default: begin
                // Done phase and the unused code ignore characters.
            end
        endcase
    end

    // State registers advance only when a character is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PhHeader;
            r_commas  <= '0;
            r_len     <= '0;
            r_ended   <= 1'b0;
            r_capped  <= 1'b0;
            r_remain  <= '0;
            r_hi      <= '0;
            r_pending <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_commas  <= n_commas;
            r_len     <= n_len;
            r_ended   <= n_ended;
            r_capped  <= n_capped;
            r_remain  <= n_remain;
            r_hi      <= n_hi;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

@@ rtl/at_response_hex_payload_decoder_top.sv @@
// Path: an accepted input item waits in the input register and is parsed into the result
// register once that register is free or being drained.
// Throughput: one character per cycle while the output side takes results; the input and
// output registers let a new item enter while a finished result still waits.
// Reset: synchronous, active low; clears both valid flags and the parse state to the header
// phase with no commas, zero length and no pending nibble.
`default_nettype none

module at_response_hex_payload_decoder_top
    import atr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [CharW-1:0] i_s_axis_tdata,   // [7:0] char_in
    input  wire logic [0:0]       i_s_axis_tuser,   // [0] start_of_response
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic [CharW-1:0]      o_m_axis_tdata,   // [7:0] data_byte
    output logic [1:0]            o_m_axis_tuser,   // [0] has_data, [1] length_capped
    output logic                  o_m_axis_tlast    // is_last
);

    logic             r_in_valid;
    logic [CharW-1:0] r_in_char;
    logic             r_in_start;
    logic             r_out_valid;
    t_result          r_out;

    logic    proc_fire;
    logic    res_valid;
    t_result res;

    // The held item is processed when the output register is free or being drained.
    assign proc_fire       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser[0];
        end
    end

    atr_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (proc_fire),
        .i_char      (r_in_char),
        .i_start     (r_in_start),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= res_valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.data;
    assign o_m_axis_tuser  = {r_out.capped, r_out.has_data};
    assign o_m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking stream testbench for the AT response hex payload decoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atr_pkg::*;

    localparam int ITEM_TARGET      = 1700;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER  = 400;
    localparam int QUIET_FROM       = 900;
    localparam int QUIET_TO         = 1100;
    localparam int TAIL_FROM        = 1400;
    localparam int DRAIN_CYCLES     = 20;

    // One row of directed stimulus; want is {capped, last, has_data, data}.
    typedef struct packed {
        logic             start;
        logic [CharW-1:0] ch;
        logic             fixed;
        t_result          want;
    } t_stim_row;

    localparam t_result BY_MODEL = '0;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [CharW-1:0] i_s_axis_tdata  = '0;
    logic [0:0]       i_s_axis_tuser  = '0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [CharW-1:0] o_m_axis_tdata;
    logic [1:0]       o_m_axis_tuser;
    logic             o_m_axis_tlast;

    // Predicted parse state.
    logic [1:0]        ph;
    logic [CommaW-1:0] commas;
    logic [LenW-1:0]   decl_len;
    logic              len_done;
    logic              len_sat;
    logic [LenW-1:0]   bytes_left;
    logic [NibbleW-1:0] hi_nib;
    logic              nib_held;

    t_result expected_bytes[$];
    int      chars_sent     = 0;
    int      bad_count      = 0;
    int      cycle_count    = 0;
    int      sink_wait      = 0;
    bit      long_hold_done = 1'b0;
    bit      idle_on        = 1'b1;
    string   hex_digits     = "0123456789abcdefABCDEF";

    // Directed responses: empty payload, saturated length cut by a sign, non-hex
    // payload characters, a response truncated by a new start, a short payload.
    t_stim_row dir_rows [0:26] = '{
        {1'b1, ",",   1'b0, BY_MODEL},
        {1'b0, ",",   1'b0, BY_MODEL},
        {1'b0, ",",   1'b0, BY_MODEL},
        {1'b0, ",",   1'b1, {1'b0, 1'b1, 1'b0, 8'h00}},
        {1'b1, ",",   1'b0, BY_MODEL},
        {1'b0, ",",   1'b0, BY_MODEL},
        {1'b0, ",",   1'b0, BY_MODEL},
        {1'b0, "9",   1'b0, BY_MODEL},
        {1'b0, "9",   1'b0, BY_MODEL},
        {1'b0, "9",   1'b0, BY_MODEL},
        {1'b0, "-",   1'b0, BY_MODEL},
        {1'b0, "5",   1'b0, BY_MODEL},
        {1'b0, ",",   1'b0, BY_MODEL},
        {1'b0, "F",   1'b0, BY_MODEL},
        {1'b0, "f",   1'b1, {1'b1, 1'b0, 1'b1, 8'hFF}},
        {1'b0, 8'hFF, 1'b0, BY_MODEL},
        {1'b0, 8'h00, 1'b1, {1'b1, 1'b0, 1'b1, 8'h00}},
        {1'b0, "A",   1'b0, BY_MODEL},
        {1'b0, "9",   1'b0, BY_MODEL},
        {1'b1, ",",   1'b0, BY_MODEL},
        {1'b0, ",",   1'b0, BY_MODEL},
        {1'b0, ",",   1'b0, BY_MODEL},
        {1'b0, "1",   1'b0, BY_MODEL},
        {1'b0, ",",   1'b0, BY_MODEL},
        {1'b0, "0",   1'b0, BY_MODEL},
        {1'b0, "7",   1'b1, {1'b0, 1'b1, 1'b1, 8'h07}},
        {1'b0, 8'hFF, 1'b0, BY_MODEL}
    };

    at_response_hex_payload_decoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] char_in
        .i_s_axis_tuser  (i_s_axis_tuser),   // [0] start_of_response
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] data_byte
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] has_data, [1] length_capped
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hex digit value of a character; anything else counts as zero.
    function automatic logic [NibbleW-1:0] hex_value(input logic [CharW-1:0] c);
        if (c >= "0" && c <= "9") return NibbleW'(c - "0");
        if (c >= "a" && c <= "f") return NibbleW'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F") return NibbleW'(c - "A" + 8'd10);
        return '0;
    endfunction

    // Return the predicted parse state to the start of a response.
    function automatic void clear_parse();
        ph         = PhHeader;
        commas     = '0;
        decl_len   = '0;
        len_done   = 1'b0;
        len_sat    = 1'b0;
        bytes_left = '0;
        hi_nib     = '0;
        nib_held   = 1'b0;
    endfunction

    // Advance the predicted state by one character; made is set when a result follows.
    task automatic decode_char(input logic start, input logic [CharW-1:0] c,
                               output bit made, output t_result res);
        int unsigned nxt;
        made = 1'b0;
        res  = '0;
        if (start) clear_parse();
        if (ph == PhHeader) begin
            if (c == FieldSep) begin
                commas = commas + 1'b1;
                if (commas >= HeaderFields) begin
                    if (decl_len == 0) begin
                        // Zero declared length ends the response with an empty result.
                        ph   = PhDone;
                        res  = {len_sat, 1'b1, 1'b0, 8'h00};
                        made = 1'b1;
                    end else begin
                        bytes_left = decl_len;
                        nib_held   = 1'b0;
                        ph         = PhPayload;
                    end
                end
            end else if (commas == LengthField && !len_done) begin
                // Leading decimal digits only, saturating at the content limit.
                if (c >= "0" && c <= "9") begin
                    nxt = decl_len * 10 + int'(c - "0");
                    if (nxt > MaxContentBytes) begin
                        nxt     = MaxContentBytes;
                        len_sat = 1'b1;
                    end
                    decl_len = LenW'(nxt);
                end else begin
                    len_done = 1'b1;
                end
            end
        end else if (ph == PhPayload) begin
            if (!nib_held) begin
                hi_nib   = hex_value(c);
                nib_held = 1'b1;
            end else begin
                res.data     = {hi_nib, hex_value(c)};
                nib_held     = 1'b0;
                hi_nib       = '0;
                if (bytes_left > 0) bytes_left = bytes_left - 1'b1;
                res.has_data = 1'b1;
                res.last     = (bytes_left == 0);
                res.capped   = len_sat;
                if (res.last) ph = PhDone;
                made = 1'b1;
            end
        end
    endtask

    // Offer one character, optionally after an idle burst, and predict it once taken.
    task automatic send_char(input logic start, input logic [CharW-1:0] c,
                             input logic fixed, input t_result want);
        bit      made;
        t_result res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tuser  <= start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        chars_sent++;
        decode_char(start, c, made, res);
        if (made) expected_bytes.push_back(fixed ? want : res);
    endtask

    // One random response: mostly well formed, some cut short, some plain noise.
    task automatic send_response();
        logic [CharW-1:0] chars[$];
        logic [CharW-1:0] c;
        string            digits;
        int               kind;
        int               n;
        int               decl;
        int               eff;
        bit               junk_lead;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                send_char($urandom_range(0, 3) == 0, CharW'($urandom_range(0, 255)),
                          1'b0, BY_MODEL);
            end
            return;
        end
        // Three header fields of arbitrary non-comma characters.
        repeat (3) begin
            n = $urandom_range(0, 3);
            repeat (n) begin
                c = CharW'($urandom_range(0, 255));
                chars.push_back(c == FieldSep ? "x" : c);
            end
            chars.push_back(FieldSep);
        end
        // Length field, small in most responses and now and then over the limit.
        n         = $urandom_range(0, 39);
        decl      = (n == 0) ? $urandom_range(200, 2000) : (n < 4) ? 0 : $urandom_range(1, 9);
        junk_lead = ($urandom_range(0, 11) == 0);
        if (junk_lead) chars.push_back($urandom_range(0, 1) ? "+" : " ");
        if ($urandom_range(0, 7) == 0) chars.push_back("0");
        digits = $sformatf("%0d", decl);
        for (int i = 0; i < digits.len(); i++) chars.push_back(digits[i]);
        if ($urandom_range(0, 5) == 0) begin
            chars.push_back(";");
            chars.push_back("7");
        end
        chars.push_back(FieldSep);
        eff = junk_lead ? 0 : (decl > MaxContentBytes ? MaxContentBytes : decl);
        // Hex pairs of mixed case with an occasional arbitrary byte.
        repeat (2 * eff) begin
            if ($urandom_range(0, 15) == 0) c = CharW'($urandom_range(0, 255));
            else c = hex_digits[$urandom_range(0, 21)];
            chars.push_back(c);
        end
        n = $urandom_range(0, 3);
        repeat (n) chars.push_back(CharW'($urandom_range(0, 255)));
        // Cut some responses short so that the next start drops the rest.
        if (kind < 4) begin
            n     = $urandom_range(1, chars.size());
            chars = chars[0:n-1];
        end
        for (int i = 0; i < chars.size(); i++) send_char(i == 0, chars[i], 1'b0, BY_MODEL);
    endtask

    // Output ready: random stalls, one long hold-off, steady near the end.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            i_m_axis_tready <= 1'b0;
        end else if (!long_hold_done && chars_sent >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            sink_wait = LONG_HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_wait = $urandom_range(0, 4);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result item with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tuser[1], o_m_axis_tlast, o_m_axis_tuser[0], o_m_axis_tdata};
            if (expected_bytes.size() == 0) begin
                bad_count++;
                if (bad_count <= 10) begin
                    $display("unexpected result: data=%h has_data=%b last=%b capped=%b",
                             got.data, got.has_data, got.last, got.capped);
                end
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $display({"mismatch: want data=%h has=%b last=%b capped=%b, ",
                                  "got data=%h has=%b last=%b capped=%b"},
                                 want.data, want.has_data, want.last, want.capped,
                                 got.data, got.has_data, got.last, got.capped);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Reset, directed rows, random responses, then drain.
    initial begin
        clear_parse();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) begin
            send_char(dir_rows[i].start, dir_rows[i].ch, dir_rows[i].fixed, dir_rows[i].want);
        end
        while (chars_sent < ITEM_TARGET) begin
            idle_on = !((chars_sent >= QUIET_FROM && chars_sent < QUIET_TO) ||
                        chars_sent >= TAIL_FROM);
            send_response();
        end
        i_s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_count == 0 && expected_bytes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
